### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths and constants for the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int W       = 32;          // datapath width, wraps as 32-bit C
    localparam int DIV_LAT = W;           // one quotient bit per divider stage
    // three front stages, ten middle stages, four tail stages, two dividers
    localparam int NSTG    = 17 + 2 * DIV_LAT;

    localparam logic [W-1:0] K_B6_OFS   = 32'd4000;
    localparam logic [W-1:0] K_B4_OFS   = 32'd32768;
    localparam logic [W-1:0] K_B7_SCALE = 32'd50000;
    localparam logic [W-1:0] K_P_SQ     = 32'd3038;
    localparam logic [W-1:0] K_P_LIN    = 32'hFFFF_E343;   // -7357
    localparam logic [W-1:0] K_P_OFS    = 32'd3791;

    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

endpackage

### rtl/bpc_udiv.sv
// ----------------------------------------------------------------------------
// bpc_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_udiv
    import bpc_pkg::*;
(
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo
);

    logic [W-1:0] rem_reg [DIV_LAT];
    logic [W-1:0] nq_reg  [DIV_LAT];
    logic [W-1:0] den_reg [DIV_LAT];
    logic [W-1:0] rem_next [DIV_LAT];
    logic [W-1:0] nq_next  [DIV_LAT];
    logic [W-1:0] den_next [DIV_LAT];

    always_comb begin
        logic [W-1:0] r_in [DIV_LAT];
        logic [W-1:0] n_in [DIV_LAT];
        logic [W:0]   trial [DIV_LAT];
        // stage 0 starts from a clear remainder
        r_in[0]     = '0;
        n_in[0]     = num;
        den_next[0] = den;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_in[k]     = rem_reg[k-1];
            n_in[k]     = nq_reg[k-1];
            den_next[k] = den_reg[k-1];
        end
        for (int k = 0; k < DIV_LAT; k++) begin
            trial[k] = {r_in[k], n_in[k][W-1]};
            if (trial[k] >= {1'b0, den_next[k]}) begin
                rem_next[k] = W'(trial[k] - {1'b0, den_next[k]});
                nq_next[k]  = {n_in[k][W-2:0], 1'b1};
            end else begin
                rem_next[k] = trial[k][W-1:0];
                nq_next[k]  = {n_in[k][W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign quo = nq_reg[DIV_LAT-1];

endmodule

### rtl/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation of a digital barometer.
// The input beat reaches the result beat through two 32-stage dividers.
// Throughput: one beat per cycle; the whole pipe advances together and
// holds when a result beat waits on m_tready.
// Reset: synchronous, active low; clears valid bits and calibration registers, sets OSS to 3.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [15:0] raw_temperature, [39:16] raw_pressure
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] temperature_tenths, [63:32] pressure_pa
    output logic [0:0]  m_tuser    // [0] divide_fault
);

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;
    logic        wr_en;
    logic [2:0]  wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg  <= '0;
            mcmd_reg <= '0;
            oss_reg  <= 2'd3;
        end else if (wr_en) begin
            case (wr_idx)
                REG_AC1_AC2: ac12_reg <= pwdata;
                REG_AC3_AC4: ac34_reg <= pwdata;
                REG_AC5_AC6: ac56_reg <= pwdata;
                REG_B1_B2:   b12_reg  <= pwdata;
                REG_MC_MD:   mcmd_reg <= pwdata;
                REG_OSS:     oss_reg  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            REG_AC1_AC2: prdata = ac12_reg;
            REG_AC3_AC4: prdata = ac34_reg;
            REG_AC5_AC6: prdata = ac56_reg;
            REG_B1_B2:   prdata = b12_reg;
            REG_MC_MD:   prdata = mcmd_reg;
            REG_OSS:     prdata = {30'd0, oss_reg};
            default:     prdata = '0;
        endcase
    end

    // calibration words, sign or zero extended to the datapath width
    logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{ac12_reg[31]}}, ac12_reg[31:16]};
    assign ac2 = {{16{ac12_reg[15]}}, ac12_reg[15:0]};
    assign ac3 = {{16{ac34_reg[31]}}, ac34_reg[31:16]};
    assign ac4 = {16'd0, ac34_reg[15:0]};
    assign ac5 = {16'd0, ac56_reg[31:16]};
    assign ac6 = {16'd0, ac56_reg[15:0]};
    assign b1  = {{16{b12_reg[31]}}, b12_reg[31:16]};
    assign b2  = {{16{b12_reg[15]}}, b12_reg[15:0]};
    assign mc  = {{16{mcmd_reg[31]}}, mcmd_reg[31:16]};
    assign md  = {{16{mcmd_reg[15]}}, mcmd_reg[15:0]};

    // ------------------------------------------------------------------
    // Flow control: the whole pipe moves when the output slot is free
    // ------------------------------------------------------------------
    logic            adv;
    logic [NSTG-1:0] vld_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Front: UT/UP capture, x1 product, first divider operands
    // ------------------------------------------------------------------
    logic [15:0]  p0_ut_reg;
    logic [W-1:0] p0_up_reg, p1_prod_reg, p1_up_reg;
    logic [W-1:0] p2_x1_reg, p2_un_reg, p2_ud_reg, p2_up_reg;
    logic         p2_sgn_reg, p2_fz_reg;

    logic [3:0]   up_sh;
    logic [W-1:0] x1_t, den_t, n1_t;
    assign up_sh = 4'd8 - {2'd0, oss_reg};
    assign x1_t  = W'($signed(p1_prod_reg) >>> 15);
    assign den_t = x1_t + md;
    assign n1_t  = mc << 11;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_ut_reg   <= s_tdata[15:0];
            p0_up_reg   <= {8'd0, s_tdata[39:16] >> up_sh};
            p1_prod_reg <= ({16'd0, p0_ut_reg} - ac6) * ac5;
            p1_up_reg   <= p0_up_reg;
            p2_x1_reg   <= x1_t;
            p2_sgn_reg  <= n1_t[W-1] ^ den_t[W-1];
            p2_fz_reg   <= (den_t == '0);
            p2_un_reg   <= n1_t[W-1]  ? (W'(0) - n1_t)  : n1_t;
            p2_ud_reg   <= den_t[W-1] ? (W'(0) - den_t) : den_t;
            p2_up_reg   <= p1_up_reg;
        end
    end

    // first divider: (mc << 11) / (x1 + md)
    logic [W-1:0] quo1;
    bpc_udiv u_div_b5 (
        .aclk (aclk),
        .en   (adv),
        .num  (p2_un_reg),
        .den  (p2_ud_reg),
        .quo  (quo1)
    );

    logic [W-1:0] d1_x1_reg  [DIV_LAT];
    logic [W-1:0] d1_up_reg  [DIV_LAT];
    logic         d1_sgn_reg [DIV_LAT];
    logic         d1_fz_reg  [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_x1_reg[0]  <= p2_x1_reg;
            d1_up_reg[0]  <= p2_up_reg;
            d1_sgn_reg[0] <= p2_sgn_reg;
            d1_fz_reg[0]  <= p2_fz_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                d1_x1_reg[k]  <= d1_x1_reg[k-1];
                d1_up_reg[k]  <= d1_up_reg[k-1];
                d1_sgn_reg[k] <= d1_sgn_reg[k-1];
                d1_fz_reg[k]  <= d1_fz_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Middle: B5, temperature, B6 products, B3, B4, B7
    // ------------------------------------------------------------------
    logic [W-1:0] p3_b5_reg, p3_up_reg;
    logic         p3_fz_reg;
    logic [W-1:0] p4_temp_reg, p4_b6_reg, p4_up_reg;
    logic         p4_fz_reg;
    logic [W-1:0] p5_sqp_reg, p5_a2_reg, p5_a3_reg, p5_temp_reg, p5_up_reg;
    logic         p5_fz_reg;
    logic [W-1:0] p6_sq_reg, p6_x2a_reg, p6_x1c_reg, p6_temp_reg, p6_up_reg;
    logic         p6_fz_reg;
    logic [W-1:0] p7_b2sq_reg, p7_b1sq_reg, p7_x2a_reg, p7_x1c_reg, p7_temp_reg, p7_up_reg;
    logic         p7_fz_reg;
    logic [W-1:0] p8_x3_reg, p8_x3p_reg, p8_temp_reg, p8_up_reg;
    logic         p8_fz_reg;
    logic [W-1:0] p9_t_reg, p9_b4p_reg, p9_temp_reg, p9_up_reg;
    logic         p9_fz_reg;
    logic [W-1:0] p10_b3_reg, p10_b4_reg, p10_temp_reg, p10_up_reg;
    logic         p10_fz_reg;
    logic [W-1:0] p11_b7_reg, p11_b4_reg, p11_temp_reg;
    logic         p11_flt_reg;
    logic [W-1:0] p12_n2_reg, p12_b4_reg, p12_temp_reg;
    logic         p12_big_reg, p12_flt_reg;

    logic [W-1:0] q1_s, b5_t, x3p_s, t_ac, b3_t;
    assign q1_s  = d1_sgn_reg[DIV_LAT-1] ? (W'(0) - quo1) : quo1;
    assign b5_t  = d1_x1_reg[DIV_LAT-1] + q1_s;
    assign x3p_s = W'($signed(p7_b1sq_reg) >>> 16) + p7_x1c_reg + W'(2);
    assign t_ac  = ((ac1 << 2) + p8_x3_reg) << oss_reg;
    // divide by four, truncating toward zero
    assign b3_t  = p9_t_reg[W-1] ? W'($signed(p9_t_reg + W'(3)) >>> 2)
                                 : W'($signed(p9_t_reg) >>> 2);

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_b5_reg    <= b5_t;
            p3_up_reg    <= d1_up_reg[DIV_LAT-1];
            p3_fz_reg    <= d1_fz_reg[DIV_LAT-1];

            p4_temp_reg  <= W'($signed(p3_b5_reg + W'(8)) >>> 4);
            p4_b6_reg    <= p3_b5_reg - K_B6_OFS;
            p4_up_reg    <= p3_up_reg;
            p4_fz_reg    <= p3_fz_reg;

            p5_sqp_reg   <= p4_b6_reg * p4_b6_reg;
            p5_a2_reg    <= ac2 * p4_b6_reg;
            p5_a3_reg    <= ac3 * p4_b6_reg;
            p5_temp_reg  <= p4_temp_reg;
            p5_up_reg    <= p4_up_reg;
            p5_fz_reg    <= p4_fz_reg;

            p6_sq_reg    <= W'($signed(p5_sqp_reg) >>> 12);
            p6_x2a_reg   <= W'($signed(p5_a2_reg) >>> 11);
            p6_x1c_reg   <= W'($signed(p5_a3_reg) >>> 13);
            p6_temp_reg  <= p5_temp_reg;
            p6_up_reg    <= p5_up_reg;
            p6_fz_reg    <= p5_fz_reg;

            p7_b2sq_reg  <= b2 * p6_sq_reg;
            p7_b1sq_reg  <= b1 * p6_sq_reg;
            p7_x2a_reg   <= p6_x2a_reg;
            p7_x1c_reg   <= p6_x1c_reg;
            p7_temp_reg  <= p6_temp_reg;
            p7_up_reg    <= p6_up_reg;
            p7_fz_reg    <= p6_fz_reg;

            p8_x3_reg    <= W'($signed(p7_b2sq_reg) >>> 11) + p7_x2a_reg;
            p8_x3p_reg   <= W'($signed(x3p_s) >>> 2);
            p8_temp_reg  <= p7_temp_reg;
            p8_up_reg    <= p7_up_reg;
            p8_fz_reg    <= p7_fz_reg;

            p9_t_reg     <= t_ac + W'(2);
            p9_b4p_reg   <= ac4 * (p8_x3p_reg + K_B4_OFS);
            p9_temp_reg  <= p8_temp_reg;
            p9_up_reg    <= p8_up_reg;
            p9_fz_reg    <= p8_fz_reg;

            p10_b3_reg   <= b3_t;
            p10_b4_reg   <= p9_b4p_reg >> 15;
            p10_temp_reg <= p9_temp_reg;
            p10_up_reg   <= p9_up_reg;
            p10_fz_reg   <= p9_fz_reg;

            p11_b7_reg   <= (p10_up_reg - p10_b3_reg) * (K_B7_SCALE >> oss_reg);
            p11_b4_reg   <= p10_b4_reg;
            p11_temp_reg <= p10_temp_reg;
            p11_flt_reg  <= p10_fz_reg || (p10_b4_reg == '0);

            // large B7 divides first and doubles after
            p12_big_reg  <= p11_b7_reg[W-1];
            p12_n2_reg   <= p11_b7_reg[W-1] ? p11_b7_reg : (p11_b7_reg << 1);
            p12_b4_reg   <= p11_b4_reg;
            p12_temp_reg <= p11_temp_reg;
            p12_flt_reg  <= p11_flt_reg;
        end
    end

    // second divider: B7 (doubled unless large) divided by B4
    logic [W-1:0] quo2;
    bpc_udiv u_div_p (
        .aclk (aclk),
        .en   (adv),
        .num  (p12_n2_reg),
        .den  (p12_b4_reg),
        .quo  (quo2)
    );

    logic [W-1:0] d2_temp_reg [DIV_LAT];
    logic         d2_big_reg  [DIV_LAT];
    logic         d2_flt_reg  [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (adv) begin
            d2_temp_reg[0] <= p12_temp_reg;
            d2_big_reg[0]  <= p12_big_reg;
            d2_flt_reg[0]  <= p12_flt_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                d2_temp_reg[k] <= d2_temp_reg[k-1];
                d2_big_reg[k]  <= d2_big_reg[k-1];
                d2_flt_reg[k]  <= d2_flt_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Tail: second-order pressure correction and output register
    // ------------------------------------------------------------------
    logic [W-1:0] p13_p_reg, p13_temp_reg;
    logic         p13_flt_reg;
    logic [W-1:0] p14_p_reg, p14_pq_reg, p14_m7_reg, p14_temp_reg;
    logic         p14_flt_reg;
    logic [W-1:0] p15_p_reg, p15_pq3_reg, p15_x2_reg, p15_temp_reg;
    logic         p15_flt_reg;
    logic [W-1:0] out_temp_reg, out_pres_reg;
    logic         out_flt_reg;

    logic [W-1:0] q8_t, corr_t, pf_t;
    assign q8_t   = W'($signed(p13_p_reg) >>> 8);
    assign corr_t = W'($signed(p15_pq3_reg) >>> 16) + p15_x2_reg + K_P_OFS;
    assign pf_t   = p15_p_reg + W'($signed(corr_t) >>> 4);

    always_ff @(posedge aclk) begin
        if (adv) begin
            p13_p_reg    <= d2_big_reg[DIV_LAT-1] ? (quo2 << 1) : quo2;
            p13_temp_reg <= d2_temp_reg[DIV_LAT-1];
            p13_flt_reg  <= d2_flt_reg[DIV_LAT-1];

            p14_pq_reg   <= q8_t * q8_t;
            p14_m7_reg   <= K_P_LIN * p13_p_reg;
            p14_p_reg    <= p13_p_reg;
            p14_temp_reg <= p13_temp_reg;
            p14_flt_reg  <= p13_flt_reg;

            p15_pq3_reg  <= p14_pq_reg * K_P_SQ;
            p15_x2_reg   <= W'($signed(p14_m7_reg) >>> 16);
            p15_p_reg    <= p14_p_reg;
            p15_temp_reg <= p14_temp_reg;
            p15_flt_reg  <= p14_flt_reg;

            // a zero divisor anywhere forces both results to zero
            out_temp_reg <= p15_flt_reg ? '0 : p15_temp_reg;
            out_pres_reg <= p15_flt_reg ? '0 : pf_t;
            out_flt_reg  <= p15_flt_reg;
        end
    end

    assign m_tdata = {out_pres_reg, out_temp_reg};
    assign m_tuser = out_flt_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("fault beat carries nonzero results");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result beat stalls");

    a_stall_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> vld_reg == $past(vld_reg))
        else $error("pipe valid bits moved during stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the barometric pressure compensation pipeline. A local integer
// model predicts each result beat from the calibration set in force; results
// are checked in order, field by field, under several idling phases.
// ----------------------------------------------------------------------------
module tb_top;
    import bpc_pkg::*;

    // expected result of one input beat
    typedef struct packed {
        logic [31:0] temp_tenths;
        logic [31:0] press_pa;
        logic        div_fault;
    } comp_result_t;

    // ordered store of expected results, checks each output beat
    class comp_scoreboard;
        comp_result_t pending[$];
        int unsigned  n_in;
        int unsigned  n_out;
        int unsigned  n_fault;
        int unsigned  n_err;

        function void note_input(comp_result_t r);
            pending.push_back(r);
            n_in++;
        endfunction

        function void check_result(logic [31:0] t, logic [31:0] p, logic f);
            comp_result_t e;
            n_out++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat t=%h p=%h f=%b", $time, t, p, f);
                n_err++;
                return;
            end
            e = pending.pop_front();
            if (f) n_fault++;
            if (e.temp_tenths !== t) begin
                $display("%0t: temperature exp %h got %h", $time, e.temp_tenths, t);
                n_err++;
            end
            if (e.press_pa !== p) begin
                $display("%0t: pressure exp %h got %h", $time, e.press_pa, p);
                n_err++;
            end
            if (e.div_fault !== f) begin
                $display("%0t: fault exp %b got %b", $time, e.div_fault, f);
                n_err++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 4000;   // cycles with no beat before giving up
    localparam int DRAIN       = NSTG + 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // [15:0] raw_temperature, [39:16] raw_pressure
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // [31:0] temperature_tenths, [63:32] pressure_pa
    logic [0:0]  m_tuser;        // [0] divide_fault

    // calibration shadow
    logic [31:0] cal_regs [0:4];
    logic [1:0]  oss_reg;

    comp_scoreboard sb;
    int  src_idle_pct;    // sender idle chance per cycle
    int  snk_stall_pct;   // receiver stall chance per cycle
    bit  hold_off;        // long receiver hold-off in progress
    int  quiet_cycles;

    always #5 aclk = ~aclk;

    barometric_pressure_compensation dut (.*);

    // -- prediction -----------------------------------------------------------
    function automatic logic [31:0] sra(logic [31:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // signed divide toward zero, most negative / -1 wraps
    function automatic logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
        logic [31:0] un, ud, q;
        un = n[31] ? -n : n;
        ud = d[31] ? -d : d;
        q  = un / ud;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic comp_result_t compensate(logic [15:0] ut_in, logic [23:0] raw_p);
        comp_result_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, q;
        int oss;
        ac1 = sx16(cal_regs[0][31:16]);  ac2 = sx16(cal_regs[0][15:0]);
        ac3 = sx16(cal_regs[1][31:16]);  ac4 = {16'd0, cal_regs[1][15:0]};
        ac5 = {16'd0, cal_regs[2][31:16]}; ac6 = {16'd0, cal_regs[2][15:0]};
        b1  = sx16(cal_regs[3][31:16]);  b2  = sx16(cal_regs[3][15:0]);
        mc  = sx16(cal_regs[4][31:16]);  md  = sx16(cal_regs[4][15:0]);
        oss = oss_reg;
        ut  = {16'd0, ut_in};
        up  = {8'd0, raw_p} >> (8 - oss);
        r   = '{temp_tenths: '0, press_pa: '0, div_fault: 1'b1};

        x1  = sra((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2  = div_trunc(mc << 11, den);
        b5  = x1 + x2;
        r.temp_tenths = sra(b5 + 8, 4);

        b6 = b5 - K_B6_OFS;
        sq = sra(b6 * b6, 12);
        x1 = sra(b2 * sq, 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = div_trunc(((ac1 * 4 + x3) << oss) + 2, 32'd4);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * sq, 16);
        x3 = sra(x1 + x2 + 2, 2);
        b4 = (ac4 * (x3 + K_B4_OFS)) >> 15;
        if (b4 == 0) begin
            r.temp_tenths = '0;
            return r;
        end
        b7 = (up - b3) * (K_B7_SCALE >> oss);
        p  = !b7[31] ? (b7 * 2) / b4 : (b7 / b4) * 2;
        q  = sra(p, 8);
        x1 = sra(q * q * K_P_SQ, 16);
        x2 = sra(K_P_LIN * p, 16);
        p  = p + sra(x1 + x2 + K_P_OFS, 4);
        r.press_pa  = p;
        r.div_fault = 1'b0;
        return r;
    endfunction

    // -- configuration --------------------------------------------------------
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_OSS) oss_reg = val[1:0];
        else cal_regs[idx] = val;
        @(posedge aclk);
    endtask

    // all six registers at once; only called with the pipe empty
    task automatic load_cal(logic [31:0] r0, r1, r2, r3, r4, logic [1:0] os);
        apb_write(REG_AC1_AC2, r0);
        apb_write(REG_AC3_AC4, r1);
        apb_write(REG_AC5_AC6, r2);
        apb_write(REG_B1_B2, r3);
        apb_write(REG_MC_MD, r4);
        apb_write(REG_OSS, {30'd0, os});
    endtask

    // typical datasheet calibration set
    task automatic load_typical(logic [1:0] os);
        load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741},
                 {16'd32757, 16'd23153}, {16'sd6190, 16'sd4},
                 {-16'sd8711, 16'sd2868}, os);
    endtask

    // -- stimulus -------------------------------------------------------------
    // tvalid stays high after a taken beat; the next idle cycle or drain drops it
    task automatic send_beat(logic [15:0] ut, logic [23:0] rp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rp, ut};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(compensate(ut, rp));
    endtask

    // raw values biased toward the realistic region, with full range noise
    task automatic send_random(int n);
        logic [15:0] ut;
        logic [23:0] rp;
        repeat (n) begin
            if ($urandom_range(3) != 0) begin
                ut = 16'd27898 + 16'($urandom_range(8000)) - 16'd4000;
                rp = 24'($urandom_range(24'hFFFFFF));
                rp[23:20] = 4'h5 + 4'($urandom_range(3));
            end else begin
                ut = 16'($urandom);
                rp = 24'($urandom);
            end
            send_beat(ut, rp);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    // -- receiver and checking ------------------------------------------------
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
        m_tready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        sb = new();
        for (int i = 0; i < 5; i++) cal_regs[i] = '0;
        oss_reg       = 2'd3;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_off      = 1'b0;
        quiet_cycles  = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset calibration: md and ac5 zero, divisor fault expected
        send_beat(16'd27898, 24'h5D23A0);
        send_beat(16'hFFFF, 24'hFFFFFF);
        drain();

        // directed: typical set at every oversampling, field extremes
        for (int os = 0; os < 4; os++) begin
            load_typical(2'(os));
            send_beat(16'd27898, 24'h5D23A0);
            send_beat(16'd0, 24'h000000);
            send_beat(16'hFFFF, 24'hFFFFFF);
            send_beat(16'h5555, 24'hAAAAAA);
            send_beat(16'hAAAA, 24'h555555);
            drain();
        end
        // b4 zero via ac4 = 0
        load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd0},
                 {16'd32757, 16'd23153}, {16'sd6190, 16'sd4},
                 {-16'sd8711, 16'sd2868}, 2'd1);
        send_beat(16'd27898, 24'h5D23A0);
        drain();
        // x1 + md zero: ut == ac6 gives x1 = 0, md = 0
        load_cal(32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71, 32'h182E_0004,
                 32'hDDF9_0000, 2'd2);
        send_beat(16'd23153, 24'h5D23A0);
        drain();
        // extreme calibration words: all ones, sign bits only, mc/md -1 wrap
        load_cal('1, '1, '1, '1, '1, 2'd3);
        send_beat(16'd0, 24'hFFFFFF);
        send_beat(16'hFFFF, 24'h000000);
        drain();
        load_cal(32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_0001, 32'h8000_7FFF,
                 32'h8000_FFFF, 2'd0);
        send_beat(16'd1, 24'h800000);
        send_beat(16'h7FFF, 24'h7FFFFF);
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = (ph == 1) ? 61 : (ph == 3) ? 33 : 0;
            snk_stall_pct = (ph == 2) ? 61 : (ph == 3) ? 33 : 0;
            if (ph == 2)
                load_cal($urandom, $urandom, $urandom, $urandom, $urandom,
                         2'($urandom));
            else
                load_typical(2'($urandom));
            send_random(130);
            // sender pauses until all results are back
            drain();
        end

        // long receiver hold-off while the sender keeps offering beats
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        load_typical(2'd3);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_random(150);
        join
        drain();

        // random calibration sets with mixed idling
        src_idle_pct  = 33;
        snk_stall_pct = 33;
        repeat (3) begin
            load_cal($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
            send_random(10);
            drain();
        end

        $display("covered %0d beats in, %0d out (%0d with divisor fault)",
                 sb.n_in, sb.n_out, sb.n_fault);
        $display("six registers, four oversampling settings, four idling phases");
        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
